// ===== rtl/core/rmr_pkg.sv =====
// Shared widths, controller command and datapath status types for the rational multiply-reduce unit.
package rmr_pkg;

    localparam int FIELD_W          = 32;
    localparam int PROD_W           = 64;
    localparam int OPERAND_BITS_DEF = 32;
    localparam int SHIFT_W          = $clog2(PROD_W);
    localparam int CNT_W            = $clog2(PROD_W);

    typedef struct packed {
        logic load;
        logic mul_n;
        logic mul_d;
        logic gcd_init;
        logic gcd_step;
        logic gcd_fin;
        logic div_step;
        logic save_n;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic zero_both;
        logic gcd_done;
        logic div_last;
    } t_sts;

endpackage

// ===== rtl/core/rmr_ifs.sv =====
// Valid/ready channel interfaces for operand requests and reduced results.
interface rmr_in_if import rmr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] a_numerator;
    logic [FIELD_W-1:0] a_denominator;
    logic [FIELD_W-1:0] b_numerator;
    logic [FIELD_W-1:0] b_denominator;

    modport source (output valid, a_numerator, a_denominator, b_numerator, b_denominator,
                    input ready);
    modport sink   (input valid, a_numerator, a_denominator, b_numerator, b_denominator,
                    output ready);
endinterface

interface rmr_out_if import rmr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [PROD_W-1:0] result_numerator;
    logic signed [PROD_W-1:0] result_denominator;
    logic                     undefined_result;

    modport source (output valid, result_numerator, result_denominator, undefined_result,
                    input ready);
    modport sink   (input valid, result_numerator, result_denominator, undefined_result,
                    output ready);
endinterface

// ===== rtl/core/rmr_datapath.sv =====
// Datapath: shared multiplier, binary gcd unit, restoring divider and result registers.
module rmr_datapath import rmr_pkg::*; #(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic [FIELD_W-1:0]       i_a_numerator,
    input  logic [FIELD_W-1:0]       i_a_denominator,
    input  logic [FIELD_W-1:0]       i_b_numerator,
    input  logic [FIELD_W-1:0]       i_b_denominator,
    output logic signed [PROD_W-1:0] o_result_numerator,
    output logic signed [PROD_W-1:0] o_result_denominator,
    output logic                     o_undefined_result
);

    localparam int MUL_W = 2 * OPERAND_BITS;

    logic signed [OPERAND_BITS-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PROD_W-1:0]       r_n, r_d;
    logic [PROD_W-1:0]              r_x, r_y, r_g;
    logic [SHIFT_W-1:0]             r_k;
    logic [PROD_W-1:0]              r_quo, r_rem;
    logic [CNT_W-1:0]               r_cnt;
    logic signed [PROD_W-1:0]       r_res_n;
    logic                           r_undef;
    logic signed [PROD_W-1:0]       r_o_num, r_o_den;
    logic                           r_o_undef;

    logic signed [OPERAND_BITS-1:0] w_mul_a, w_mul_b;
    logic signed [MUL_W-1:0]        w_prod;
    logic [PROD_W-1:0]              w_mag_n, w_mag_d;
    logic [PROD_W-1:0]              w_rem_sh;
    logic                           w_ge;
    logic signed [PROD_W-1:0]       w_quo_n, w_quo_d;

    // one multiplier, numerator product first, denominator product next
    assign w_mul_a = i_cmd.mul_d ? r_ad : r_an;
    assign w_mul_b = i_cmd.mul_d ? r_bd : r_bn;
    assign w_prod  = w_mul_a * w_mul_b;

    assign w_mag_n = r_n[PROD_W-1] ? (~r_n + PROD_W'(1)) : r_n;
    assign w_mag_d = r_d[PROD_W-1] ? (~r_d + PROD_W'(1)) : r_d;

    // restoring divide, one quotient bit per cycle
    assign w_rem_sh = {r_rem[PROD_W-2:0], r_quo[PROD_W-1]};
    assign w_ge     = (w_rem_sh >= r_g);

    assign w_quo_n = r_n[PROD_W-1] ? (~r_quo + PROD_W'(1)) : r_quo;
    assign w_quo_d = r_d[PROD_W-1] ? (~r_quo + PROD_W'(1)) : r_quo;

    assign o_sts.zero_both = (r_n == '0) && (r_d == '0);
    assign o_sts.gcd_done  = (r_x == '0) || (r_y == '0);
    assign o_sts.div_last  = &r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_an <= i_a_numerator[OPERAND_BITS-1:0];
            r_ad <= i_a_denominator[OPERAND_BITS-1:0];
            r_bn <= i_b_numerator[OPERAND_BITS-1:0];
            r_bd <= i_b_denominator[OPERAND_BITS-1:0];
        end
        if (i_cmd.mul_n) begin
            r_n <= PROD_W'(w_prod);
        end
        if (i_cmd.mul_d) begin
            r_d <= PROD_W'(w_prod);
        end
        if (i_cmd.gcd_init) begin
            r_x     <= w_mag_n;
            r_y     <= w_mag_d;
            r_k     <= '0;
            r_undef <= o_sts.zero_both;
        end
        // binary gcd: strip shared twos, strip lone twos, subtract odd from odd
        if (i_cmd.gcd_step) begin
            if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + SHIFT_W'(1);
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
        if (i_cmd.gcd_fin) begin
            r_g   <= (r_x | r_y) << r_k;
            r_quo <= w_mag_n;
            r_rem <= '0;
        end
        if (i_cmd.save_n) begin
            r_res_n <= w_quo_n;
            r_quo   <= w_mag_d;
            r_rem   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? (w_rem_sh - r_g) : w_rem_sh;
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
        end
        if (i_cmd.out_load) begin
            r_o_num   <= r_undef ? '0 : r_res_n;
            r_o_den   <= r_undef ? '0 : w_quo_d;
            r_o_undef <= r_undef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.gcd_fin || i_cmd.save_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_result_numerator   = r_o_num;
    assign o_result_denominator = r_o_den;
    assign o_undefined_result   = r_o_undef;

endmodule

// ===== rtl/core/rmr_ctrl.sv =====
// Controller: sequences multiply, gcd, two divisions and the result handoff.
module rmr_ctrl import rmr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_MUL_N   = 9'b000000010,
        S_MUL_D   = 9'b000000100,
        S_GCD_CHK = 9'b000001000,
        S_GCD     = 9'b000010000,
        S_DIV_N   = 9'b000100000,
        S_SAVE_N  = 9'b001000000,
        S_DIV_D   = 9'b010000000,
        S_FIN     = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_N;
                end
            end
            S_MUL_N: begin
                o_cmd.mul_n = 1'b1;
                n_state     = S_MUL_D;
            end
            S_MUL_D: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_GCD_CHK;
            end
            S_GCD_CHK: begin
                o_cmd.gcd_init = 1'b1;
                n_state        = i_sts.zero_both ? S_FIN : S_GCD;
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.gcd_fin = 1'b1;
                    n_state       = S_DIV_N;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV_N: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SAVE_N;
                end
            end
            S_SAVE_N: begin
                o_cmd.save_n = 1'b1;
                n_state      = S_DIV_D;
            end
            S_DIV_D: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/rational_multiply_reduce_unit.sv =====
// Rational multiply with gcd reduction: N = an*bn, D = ad*bd, result N/G, D/G, G = gcd(|N|,|D|).
// Sequence: capture, both products and the zero check, then binary-gcd steps (their number set
// by operand bit lengths) and forming the divisor, then two restoring divisions of the 64-bit
// magnitudes by the gcd, then loading the result register. When both products are zero the
// gcd and divisions are skipped. One request in flight; the next is taken once the result
// sits in the output register. Sync active-low reset: idle, valid low.
module rational_multiply_reduce_unit import rmr_pkg::*; #(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmr_in_if.sink     i_req,
    rmr_out_if.source  o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    rmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rmr_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_a_numerator        (i_req.a_numerator),
        .i_a_denominator      (i_req.a_denominator),
        .i_b_numerator        (i_req.b_numerator),
        .i_b_denominator      (i_req.b_denominator),
        .o_result_numerator   (o_rsp.result_numerator),
        .o_result_denominator (o_rsp.result_denominator),
        .o_undefined_result   (o_rsp.undefined_result)
    );

endmodule

// ===== tb/rational_multiply_reduce_unit_tb.sv =====
// Self-checking testbench for the rational multiply-reduce unit: random traffic, predicted results.
module rational_multiply_reduce_unit_tb;
    import rmr_pkg::*;

    localparam int OP_BITS      = OPERAND_BITS_DEF;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 2_000_000;

    localparam logic [FIELD_W-1:0] MIN_OP = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] MAX_OP = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] NEG_1  = 32'hFFFF_FFFF;

    typedef struct {
        logic [FIELD_W-1:0] an;
        logic [FIELD_W-1:0] ad;
        logic [FIELD_W-1:0] bn;
        logic [FIELD_W-1:0] bd;
    } t_operands;

    typedef struct {
        logic signed [PROD_W-1:0] num;
        logic signed [PROD_W-1:0] den;
        logic                     undef;
    } t_fraction;

    logic clk;
    logic rst_n;

    rmr_in_if  req_if ();
    rmr_out_if rsp_if ();

    rational_multiply_reduce_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_operands operand_queue[$];
    t_fraction expected_fractions[$];
    int        requests_sent;
    int        results_seen;
    int        mismatch_cnt;
    int        cycle_cnt;
    int        burst_left;
    int        gap_left;
    int        stall_hold;

    // Take the low OP_BITS bits of a field, sign-extended to product width.
    function automatic logic signed [PROD_W-1:0] widen(logic [FIELD_W-1:0] raw);
        logic signed [PROD_W-1:0] t;
        t = {{(PROD_W-FIELD_W){1'b0}}, raw};
        t = t <<< (PROD_W - OP_BITS);
        return t >>> (PROD_W - OP_BITS);
    endfunction

    function automatic t_fraction reduce_fraction_product(t_operands op);
        logic signed [PROD_W-1:0] n;
        logic signed [PROD_W-1:0] d;
        logic [PROD_W-1:0]        mn;
        logic [PROD_W-1:0]        md;
        logic [PROD_W-1:0]        x;
        logic [PROD_W-1:0]        y;
        logic [PROD_W-1:0]        r;
        logic [PROD_W-1:0]        qn;
        logic [PROD_W-1:0]        qd;
        t_fraction                res;
        n  = widen(op.an) * widen(op.bn);
        d  = widen(op.ad) * widen(op.bd);
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        x  = mn;
        y  = md;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        if (x == 0) begin
            res.num   = '0;
            res.den   = '0;
            res.undef = 1'b1;
        end else begin
            qn        = mn / x;
            qd        = md / x;
            res.num   = (n < 0) ? -qn : qn;
            res.den   = (d < 0) ? -qd : qd;
            res.undef = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_operand();
        logic [FIELD_W-1:0] v;
        int                 sel;
        sel = $urandom_range(0, 15);
        if (sel <= 4) begin
            v = $urandom;
        end else if (sel <= 7) begin
            v = int'($urandom_range(0, 64)) - 32;
        end else if (sel == 8) begin
            case ($urandom_range(0, 3))
                0:       v = MIN_OP;
                1:       v = MAX_OP;
                2:       v = '0;
                default: v = NEG_1;
            endcase
        end else if (sel <= 10) begin
            v = 32'd1 << $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) v = -v;
        end else if (sel <= 13) begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) v = -v;
        end else begin
            // products of small factors give large gcds
            v = 1;
            repeat ($urandom_range(2, 9)) v = v * $urandom_range(2, 13);
            if ($urandom_range(0, 1) == 1) v = -v;
        end
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] scaled(int f);
        return f * (int'($urandom_range(0, 80000)) - 40000);
    endfunction

    function automatic t_operands random_operands();
        t_operands op;
        int        sel;
        int        f;
        sel   = $urandom_range(0, 99);
        op.an = pick_operand();
        op.ad = pick_operand();
        op.bn = pick_operand();
        op.bd = pick_operand();
        if (sel < 40) begin
            f     = $urandom_range(1, 5000);
            op.an = scaled(f);
            op.ad = scaled(f);
            op.bn = scaled($urandom_range(1, 5000));
            op.bd = scaled(f);
        end else if (sel < 50) begin
            op.bd = 1;
        end else if (sel < 55) begin
            case ($urandom_range(0, 2))
                0: begin op.an = '0; op.bd = '0; end
                1: op.bn = '0;
                default: op.ad = '0;
            endcase
        end
        return op;
    endfunction

    task automatic add_item(logic [FIELD_W-1:0] an, logic [FIELD_W-1:0] ad,
                            logic [FIELD_W-1:0] bn, logic [FIELD_W-1:0] bd);
        t_operands op;
        op.an = an;
        op.ad = ad;
        op.bn = bn;
        op.bd = bd;
        operand_queue.push_back(op);
    endtask

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Request driver: bursts with random gaps; in every 500 requests the last 100 run without gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            burst_left   <= 1;
            gap_left     <= 0;
        end else if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0 || operand_queue.size() == 0) begin
                req_if.valid <= 1'b0;
                if (gap_left != 0) gap_left <= gap_left - 1;
            end else begin
                req_if.a_numerator   <= operand_queue[0].an;
                req_if.a_denominator <= operand_queue[0].ad;
                req_if.b_numerator   <= operand_queue[0].bn;
                req_if.b_denominator <= operand_queue[0].bd;
                req_if.valid         <= 1'b1;
                operand_queue.pop_front();
                requests_sent <= requests_sent + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= ((requests_sent / 100) % 5 == 4) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Result sink: ready held at random levels, with calm windows of no stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_hold   <= 0;
        end else if (stall_hold == 0) begin
            if ((results_seen / 50) % 4 == 3) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 2) != 0);
                stall_hold   <= $urandom_range(0, 9);
            end
        end else begin
            stall_hold <= stall_hold - 1;
        end
    end

    // Result check first, then record the prediction for a request accepted at this edge.
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            results_seen <= results_seen + 1;
            if (expected_fractions.size() == 0) begin
                $error("unexpected result: %0d/%0d undefined=%0b", rsp_if.result_numerator,
                       rsp_if.result_denominator, rsp_if.undefined_result);
                mismatch_cnt = mismatch_cnt + 1;
            end else begin
                if (rsp_if.result_numerator !== expected_fractions[0].num) begin
                    $error("result_numerator: expected %0d, got %0d",
                           expected_fractions[0].num, rsp_if.result_numerator);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (rsp_if.result_denominator !== expected_fractions[0].den) begin
                    $error("result_denominator: expected %0d, got %0d",
                           expected_fractions[0].den, rsp_if.result_denominator);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (rsp_if.undefined_result !== expected_fractions[0].undef) begin
                    $error("undefined_result: expected %0b, got %0b",
                           expected_fractions[0].undef, rsp_if.undefined_result);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                expected_fractions.pop_front();
            end
        end
        if (rst_n && req_if.valid && req_if.ready) begin
            expected_fractions.push_back(reduce_fraction_product('{req_if.a_numerator,
                req_if.a_denominator, req_if.b_numerator, req_if.b_denominator}));
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.a_numerator   = '0;
        req_if.a_denominator = '0;
        req_if.b_numerator   = '0;
        req_if.b_denominator = '0;
        rsp_if.ready         = 1'b0;
        requests_sent        = 0;
        results_seen         = 0;
        mismatch_cnt         = 0;
        cycle_cnt            = 0;

        add_item(1, 1, 1, 1);
        add_item(0, 1, 5, 7);                   // zero numerator, positive denominator
        add_item(0, -3, 5, 7);                  // zero numerator, negative denominator
        add_item(0, 0, 5, 7);                   // both products zero
        add_item(0, 5, 3, 0);
        add_item(0, 0, 0, 0);
        add_item(3, 0, 4, 5);                   // zero denominator
        add_item(-3, 0, 4, 5);
        add_item(MIN_OP, MIN_OP, MIN_OP, MIN_OP);
        add_item(MIN_OP, 1, MIN_OP, 1);         // largest product magnitude
        add_item(MIN_OP, 1, MAX_OP, 1);
        add_item(MAX_OP, MAX_OP, MAX_OP, MAX_OP);
        add_item(MAX_OP, 1, MAX_OP, NEG_1);
        add_item(3, 4, 8, 1);                   // integer multiply
        add_item(-6, 4, 5, 1);
        add_item(2, -3, 3, 5);
        add_item(NEG_1, NEG_1, NEG_1, NEG_1);
        add_item(NEG_1, MIN_OP, 1, 1);
        add_item(12, 18, 35, 21);
        add_item(MIN_OP, 3, 3, MIN_OP);
        add_item(MAX_OP, 32'h7FFF_FFED, 1, 1);
        add_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC);
        add_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h3333_3333);
        repeat (RANDOM_ITEMS) operand_queue.push_back(random_operands());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (operand_queue.size() != 0 || req_if.valid) @(posedge clk);
        while (expected_fractions.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rmr_pkg.sv
rtl/core/rmr_ifs.sv
rtl/core/rmr_datapath.sv
rtl/core/rmr_ctrl.sv
rtl/core/rational_multiply_reduce_unit.sv
tb/rational_multiply_reduce_unit_tb.sv
